FILE: rtl/pqbp_pkg.sv
// Shared types, codes and constants of the priority queue burst packer.
// Used by every module of the block but pqbp_mem; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pqbp_pkg;

	localparam int ID_W       = 29;
	localparam int DLEN_W     = 7;
	localparam int REF_W      = 16;
	localparam int MSG_W      = 7;
	localparam int BYTES_W    = 11;
	localparam int IDX_W      = 6;
	localparam int KIND_W     = 2;
	localparam int CLS_W      = 2;
	localparam int CFG_ADDR_W = 3;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 80;
	localparam int ENTRY_W    = ID_W + DLEN_W + REF_W;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int BATCH_SIZE_DEF  = 16;

	// Largest payload, header bytes per message, largest message size.
	localparam logic [DLEN_W-1:0]  MAX_DLEN   = 7'd64;
	localparam logic [MSG_W-1:0]   HDR_BYTES  = 7'd16;
	localparam int                 MSG_MAX    = 80;
	localparam int                 BYTES_SAT  = 2047;

	localparam logic [ID_W-1:0]    RST_CRIT_LO = 29'h000;
	localparam logic [ID_W-1:0]    RST_CRIT_HI = 29'h100;
	localparam logic [ID_W-1:0]    RST_HIGH_LO = 29'h101;
	localparam logic [ID_W-1:0]    RST_HIGH_HI = 29'h400;
	localparam logic [BYTES_W-1:0] RST_BASE    = 11'd38;
	localparam logic [BYTES_W-1:0] RST_LIMIT   = 11'd1450;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CRIT_LO = 3'd0,
		REG_CRIT_HI = 3'd1,
		REG_HIGH_LO = 3'd2,
		REG_HIGH_HI = 3'd3,
		REG_BASE    = 3'd4,
		REG_LIMIT   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_DROP   = 2'd1,
		KIND_BURST  = 2'd2
	} kind_t;

	typedef enum logic [CLS_W-1:0] {
		CLS_CRIT = 2'd0,
		CLS_HIGH = 2'd1,
		CLS_LOW  = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLS_CRIT,
		ST_CLS_HIGH,
		ST_PUSH,
		ST_READ,
		ST_DATA,
		ST_CHECK
	} st_t;

	typedef struct packed {
		logic [ID_W-1:0]    crit_lo;
		logic [ID_W-1:0]    crit_hi;
		logic [ID_W-1:0]    high_lo;
		logic [ID_W-1:0]    high_hi;
		logic [BYTES_W-1:0] base;
		logic [BYTES_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		logic [ID_W-1:0]    can_id;
		logic [DLEN_W-1:0]  data_len;
		logic [REF_W-1:0]   frame_ref;
	} in_t;

	// Stored queue entry, id in the low bits.
	typedef struct packed {
		logic [REF_W-1:0]   frame_ref;
		logic [DLEN_W-1:0]  data_len;
		logic [ID_W-1:0]    can_id;
	} entry_t;

	typedef struct packed {
		kind_t              kind;
		cls_t               cls;
		logic [ID_W-1:0]    can_id;
		logic [DLEN_W-1:0]  data_len;
		logic [REF_W-1:0]   frame_ref;
		logic [MSG_W-1:0]   msg_bytes;
		logic [BYTES_W-1:0] burst_bytes;
		logic [IDX_W-1:0]   msg_index;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/priority_queue_burst_packer.sv
// A push passes CLS_CRIT, CLS_HIGH if the id misses the critical range, and PUSH, which
// registers its result once the output register is free. A burst message passes READ, DATA
// and CHECK after the tick or the accepted critical push; CHECK registers it once the
// output register is free. One item at a time; ready returns once the item's last result is
// registered; a tick on empty queues gives no result. The sequencer shares its range
// compare unit and single queue memory port. arst_n resets state, pointers, counts, config.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_burst_packer #(
	parameter int QUEUE_DEPTH = pqbp_pkg::QUEUE_DEPTH_DEF,
	parameter int BATCH_SIZE  = pqbp_pkg::BATCH_SIZE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// can_id[28:0], data_len[35:29], frame_ref[51:36], zero[55:52]
	input  wire logic [pqbp_pkg::S_TDATA_W-1:0]   s_tdata,
	// operation[0]
	input  wire logic [0:0]                       s_tuser,
	// Output stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// priority_class[1:0], out_can_id[30:2], out_data_len[37:31], out_frame_ref[53:38],
	// message_bytes[60:54], burst_bytes[71:61], message_index[77:72], zero[79:78]
	output logic      [pqbp_pkg::M_TDATA_W-1:0]   m_tdata,
	// kind[1:0]
	output logic      [pqbp_pkg::KIND_W-1:0]      m_tuser,
	output logic                                  m_tlast,
	// Configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [pqbp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [pqbp_pkg::ID_W-1:0]        cfg_wdata
);

	pqbp_pkg::cfg_t  cfg;
	pqbp_pkg::in_t   in_item;
	pqbp_pkg::res_t  res;
	logic            emit;
	logic            out_free;
	logic            core_ready;

	logic                             m_tvalid_q;
	logic [pqbp_pkg::M_TDATA_W-1:0]   m_tdata_q;
	logic [pqbp_pkg::KIND_W-1:0]      m_tuser_q;
	logic                             m_tlast_q;

	pqbp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Unpack the input word.
	assign in_item.op        = pqbp_pkg::op_t'(s_tuser[0]);
	assign in_item.can_id    = s_tdata[28:0];
	assign in_item.data_len  = s_tdata[35:29];
	assign in_item.frame_ref = s_tdata[51:36];

	// The output register frees when empty or when its word is taken this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	pqbp_core #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.BATCH_SIZE  (BATCH_SIZE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_item  (in_item),
		.in_ready (core_ready),
		.cfg      (cfg),
		.out_free (out_free),
		.emit     (emit),
		.res      (res)
	);

	assign s_tready = core_ready;

	// Output word register: load on emit, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {2'b00, res.msg_index, res.burst_bytes, res.msg_bytes,
			              res.frame_ref, res.data_len, res.can_id, res.cls};
			m_tuser_q <= res.kind;
			m_tlast_q <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

FILE: rtl/pqbp_regs.sv
// Configuration register file: class id ranges and burst byte settings.
// Depends on pqbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqbp_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pqbp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [pqbp_pkg::ID_W-1:0]        cfg_wdata,
	output pqbp_pkg::cfg_t                        cfg
);

	pqbp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crit_lo <= pqbp_pkg::RST_CRIT_LO;
			cfg_q.crit_hi <= pqbp_pkg::RST_CRIT_HI;
			cfg_q.high_lo <= pqbp_pkg::RST_HIGH_LO;
			cfg_q.high_hi <= pqbp_pkg::RST_HIGH_HI;
			cfg_q.base    <= pqbp_pkg::RST_BASE;
			cfg_q.limit   <= pqbp_pkg::RST_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pqbp_pkg::REG_CRIT_LO: cfg_q.crit_lo <= cfg_wdata;
				pqbp_pkg::REG_CRIT_HI: cfg_q.crit_hi <= cfg_wdata;
				pqbp_pkg::REG_HIGH_LO: cfg_q.high_lo <= cfg_wdata;
				pqbp_pkg::REG_HIGH_HI: cfg_q.high_hi <= cfg_wdata;
				pqbp_pkg::REG_BASE:    cfg_q.base    <= cfg_wdata[pqbp_pkg::BYTES_W-1:0];
				pqbp_pkg::REG_LIMIT:   cfg_q.limit   <= cfg_wdata[pqbp_pkg::BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/pqbp_range.sv
// Shared range compare unit: lo <= x <= hi on id-wide operands.
// Depends on pqbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqbp_range (
	input  wire logic [pqbp_pkg::ID_W-1:0] x,
	input  wire logic [pqbp_pkg::ID_W-1:0] lo,
	input  wire logic [pqbp_pkg::ID_W-1:0] hi,
	output logic                           hit
);

	assign hit = (x >= lo) && (x <= hi);

endmodule

`default_nettype wire

FILE: rtl/pqbp_mem.sv
// Queue entry storage: one write port, one read port with registered data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module pqbp_mem #(
	parameter int DEPTH  = 192,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 52
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/pqbp_core.sv
// Sequencer of the packer: classify, push, and burst drain over the shared
// range unit and the queue memory. Depends on pqbp_pkg, pqbp_range, pqbp_mem.
`timescale 1ns / 1ps
`default_nettype none

module pqbp_core #(
	parameter int QUEUE_DEPTH = pqbp_pkg::QUEUE_DEPTH_DEF,
	parameter int BATCH_SIZE  = pqbp_pkg::BATCH_SIZE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire pqbp_pkg::in_t  in_item,
	output logic                in_ready,
	input  wire pqbp_pkg::cfg_t cfg,
	input  wire logic           out_free,
	output logic                emit,
	output pqbp_pkg::res_t      res
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(3 * QUEUE_DEPTH);
	localparam int LEN_W  = $clog2(pqbp_pkg::BYTES_SAT + 1 + BATCH_SIZE * pqbp_pkg::MSG_MAX);
	localparam int SUM_W  = CNT_W + 2;

	pqbp_pkg::st_t state_q, state_d;

	logic [PTR_W-1:0] heads_q  [3];
	logic [PTR_W-1:0] tails_q  [3];
	logic [CNT_W-1:0] counts_q [3];

	pqbp_pkg::in_t    item_q;
	pqbp_pkg::cls_t   cls_q;
	pqbp_pkg::cls_t   rd_cls;
	logic [LEN_W-1:0] len_q;
	logic [pqbp_pkg::IDX_W-1:0] sent_q;
	logic [pqbp_pkg::MSG_W-1:0] msg_q;

	logic [pqbp_pkg::DLEN_W-1:0] dlen_clamp;
	logic [pqbp_pkg::DLEN_W-1:0] pad_len;
	logic [pqbp_pkg::MSG_W-1:0]  msg_w;
	logic                        full;
	logic                        any_q;
	logic                        last_c;
	logic                        push_we;
	logic                        pop_en;

	logic [pqbp_pkg::ID_W-1:0] rng_x, rng_lo, rng_hi;
	logic                      rng_hit;

	logic [ADDR_W-1:0]            waddr, raddr;
	logic [pqbp_pkg::ENTRY_W-1:0] rdata;
	pqbp_pkg::entry_t             wentry, rentry;

	function automatic logic [ADDR_W-1:0] slot_addr(pqbp_pkg::cls_t c, logic [PTR_W-1:0] p);
		logic [ADDR_W-1:0] base;
		unique case (c)
			pqbp_pkg::CLS_CRIT: base = '0;
			pqbp_pkg::CLS_HIGH: base = ADDR_W'(QUEUE_DEPTH);
			default:            base = ADDR_W'(2 * QUEUE_DEPTH);
		endcase
		return base + ADDR_W'(p);
	endfunction

	function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	pqbp_range u_range (
		.x   (rng_x),
		.lo  (rng_lo),
		.hi  (rng_hi),
		.hit (rng_hit)
	);

	pqbp_mem #(
		.DEPTH  (3 * QUEUE_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (pqbp_pkg::ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (push_we),
		.waddr (waddr),
		.wdata (wentry),
		.re    (pop_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rentry = pqbp_pkg::entry_t'(rdata);

	assign dlen_clamp = (in_item.data_len > pqbp_pkg::MAX_DLEN) ? pqbp_pkg::MAX_DLEN
	                                                            : in_item.data_len;
	assign pad_len    = rentry.data_len + 7'd3;
	assign msg_w      = pqbp_pkg::HDR_BYTES + {pad_len[pqbp_pkg::DLEN_W-1:2], 2'b00};

	assign full  = (counts_q[cls_q] == CNT_W'(QUEUE_DEPTH));
	assign any_q = (counts_q[0] != '0) || (counts_q[1] != '0) || (counts_q[2] != '0);

	always_comb begin
		priority if (counts_q[0] != '0) rd_cls = pqbp_pkg::CLS_CRIT;
		else if (counts_q[1] != '0)     rd_cls = pqbp_pkg::CLS_HIGH;
		else                            rd_cls = pqbp_pkg::CLS_LOW;
	end

	// Shared unit operands: id ranges while classifying, byte limit in the check.
	always_comb begin
		unique case (state_q)
			pqbp_pkg::ST_CLS_CRIT: begin
				rng_x  = item_q.can_id;
				rng_lo = cfg.crit_lo;
				rng_hi = cfg.crit_hi;
			end
			pqbp_pkg::ST_CLS_HIGH: begin
				rng_x  = item_q.can_id;
				rng_lo = cfg.high_lo;
				rng_hi = cfg.high_hi;
			end
			default: begin
				rng_x  = pqbp_pkg::ID_W'(len_q);
				rng_lo = '0;
				rng_hi = pqbp_pkg::ID_W'(cfg.limit);
			end
		endcase
	end

	assign last_c = !rng_hit || (sent_q == pqbp_pkg::IDX_W'(BATCH_SIZE - 1)) || !any_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pqbp_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_item.op == pqbp_pkg::OP_PUSH) state_d = pqbp_pkg::ST_CLS_CRIT;
					else if (any_q)                      state_d = pqbp_pkg::ST_READ;
				end
			end
			pqbp_pkg::ST_CLS_CRIT: begin
				state_d = rng_hit ? pqbp_pkg::ST_PUSH : pqbp_pkg::ST_CLS_HIGH;
			end
			pqbp_pkg::ST_CLS_HIGH: state_d = pqbp_pkg::ST_PUSH;
			pqbp_pkg::ST_PUSH: begin
				if (out_free) begin
					state_d = (!full && cls_q == pqbp_pkg::CLS_CRIT) ? pqbp_pkg::ST_READ
					                                                 : pqbp_pkg::ST_IDLE;
				end
			end
			pqbp_pkg::ST_READ: state_d = pqbp_pkg::ST_DATA;
			pqbp_pkg::ST_DATA: state_d = pqbp_pkg::ST_CHECK;
			pqbp_pkg::ST_CHECK: begin
				if (out_free) begin
					state_d = last_c ? pqbp_pkg::ST_IDLE : pqbp_pkg::ST_READ;
				end
			end
			default: state_d = pqbp_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = (state_q == pqbp_pkg::ST_IDLE);
		emit     = 1'b0;
		push_we  = 1'b0;
		pop_en   = 1'b0;
		waddr    = slot_addr(cls_q, tails_q[cls_q]);
		raddr    = slot_addr(rd_cls, heads_q[rd_cls]);
		wentry.can_id    = item_q.can_id;
		wentry.data_len  = item_q.data_len;
		wentry.frame_ref = item_q.frame_ref;

		res.kind        = pqbp_pkg::KIND_BURST;
		res.cls         = cls_q;
		res.can_id      = rentry.can_id;
		res.data_len    = rentry.data_len;
		res.frame_ref   = rentry.frame_ref;
		res.msg_bytes   = msg_q;
		res.burst_bytes = (len_q > LEN_W'(pqbp_pkg::BYTES_SAT))
		                  ? pqbp_pkg::BYTES_W'(pqbp_pkg::BYTES_SAT)
		                  : len_q[pqbp_pkg::BYTES_W-1:0];
		res.msg_index   = sent_q;
		res.last        = last_c;

		unique case (state_q)
			pqbp_pkg::ST_PUSH: begin
				emit          = out_free;
				push_we       = out_free && !full;
				res.kind      = full ? pqbp_pkg::KIND_DROP : pqbp_pkg::KIND_ACCEPT;
				res.can_id    = item_q.can_id;
				res.data_len  = item_q.data_len;
				res.frame_ref = item_q.frame_ref;
				res.msg_bytes   = '0;
				res.burst_bytes = '0;
				res.msg_index   = '0;
				res.last      = full || (cls_q != pqbp_pkg::CLS_CRIT);
			end
			pqbp_pkg::ST_READ:  pop_en = 1'b1;
			pqbp_pkg::ST_CHECK: emit   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqbp_pkg::ST_IDLE;
			for (int i = 0; i < 3; i++) begin
				heads_q[i]  <= '0;
				tails_q[i]  <= '0;
				counts_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (push_we) begin
				tails_q[cls_q]  <= next_slot(tails_q[cls_q]);
				counts_q[cls_q] <= counts_q[cls_q] + 1'b1;
			end
			if (pop_en) begin
				heads_q[rd_cls]  <= next_slot(heads_q[rd_cls]);
				counts_q[rd_cls] <= counts_q[rd_cls] - 1'b1;
			end
		end
	end

	// Item and burst datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			pqbp_pkg::ST_IDLE: begin
				if (in_valid) begin
					item_q          <= in_item;
					item_q.data_len <= dlen_clamp;
					len_q           <= LEN_W'(cfg.base);
					sent_q          <= '0;
				end
			end
			pqbp_pkg::ST_CLS_CRIT: begin
				if (rng_hit) cls_q <= pqbp_pkg::CLS_CRIT;
			end
			pqbp_pkg::ST_CLS_HIGH: cls_q <= rng_hit ? pqbp_pkg::CLS_HIGH : pqbp_pkg::CLS_LOW;
			pqbp_pkg::ST_READ:     cls_q <= rd_cls;
			pqbp_pkg::ST_DATA: begin
				len_q <= len_q + LEN_W'(msg_w);
				msg_q <= msg_w;
			end
			pqbp_pkg::ST_CHECK: begin
				if (out_free) sent_q <= sent_q + 1'b1;
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(counts_q[0] <= CNT_W'(QUEUE_DEPTH)) && (counts_q[1] <= CNT_W'(QUEUE_DEPTH)) &&
		(counts_q[2] <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue count above depth");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pqbp_pkg::ST_READ |-> any_q)
		else $error("burst read with all queues empty");

	a_pop_total: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |=> (SUM_W'(counts_q[0]) + SUM_W'(counts_q[1]) + SUM_W'(counts_q[2])) ==
		           ($past(SUM_W'(counts_q[0]) + SUM_W'(counts_q[1]) + SUM_W'(counts_q[2]))
		            - 1'b1))
		else $error("pop did not remove exactly one entry");

	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pqbp_pkg::ST_CHECK |-> sent_q < pqbp_pkg::IDX_W'(BATCH_SIZE))
		else $error("burst exceeded batch size");

endmodule

`default_nettype wire
